FILE: sv/fce_pkg.sv
// Package for the frame counter extender.
// Holds the transaction payload types, the command codes and the shared constants.
// No dependencies.
`default_nettype none

package fce_pkg;

	// Width and reset value of the offset limit register.
	localparam int unsigned LimitW = 30;
	localparam logic [LimitW-1:0] LimitReset = 30'd1000;

	// A drop of more than this much in the adjusted count is taken as a wrap.
	localparam logic [31:0] WrapWindow = 32'h4000_0000;

	// Command codes.
	localparam logic CmdExtend  = 1'b0;
	localparam logic CmdConvert = 1'b1;

	// One input transaction.
	typedef struct packed {
		logic        cmd;
		logic [31:0] kernel_count;
		logic [63:0] target_count;
		logic        read_ok;
	} item_t;

	// One result transaction.
	typedef struct packed {
		logic [63:0] local_count;
		logic [31:0] kernel_target;
	} result_t;

endpackage

`default_nettype wire

FILE: sv/fce_datapath.sv
// Count state and the single-pass datapath of the frame counter extender.
// Holds offset, previous count and wrap count; computes one result from one item.
// Depends on fce_pkg.
`default_nettype none

module fce_datapath (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         commit,
	input  wire fce_pkg::item_t               item,
	input  wire logic [fce_pkg::LimitW-1:0]   limit,
	output fce_pkg::result_t                  result
);

	logic [31:0] offset_q;
	logic [31:0] prev_q;
	logic [31:0] wrap_q;

	logic        do_ext;
	logic        do_resync;
	logic [31:0] adj;
	logic [31:0] delta;
	logic        wrap_hit;
	logic [31:0] wrap_next;
	logic [63:0] ext_local;
	logic signed [63:0] diff;
	logic signed [63:0] lim64;
	logic        beyond;
	logic [31:0] off_sum;
	logic signed [31:0] lim32;
	logic        in_window;
	logic [31:0] offset_next;

	// Extension of the hardware count with the current offset and wrap count.
	always_comb begin
		do_ext    = (item.cmd == fce_pkg::CmdExtend) || item.read_ok;
		adj       = item.kernel_count + offset_q;
		delta     = adj - prev_q;
		wrap_hit  = delta[31] && (delta < (32'd0 - fce_pkg::WrapWindow));
		wrap_next = wrap_q + {31'd0, wrap_hit};
		ext_local = {wrap_next, adj};
	end

	// Offset resynchronization when the target drifts beyond the limit.
	always_comb begin
		diff        = $signed(item.target_count - ext_local);
		lim64       = $signed({{(64 - fce_pkg::LimitW){1'b0}}, limit});
		lim32       = $signed({{(32 - fce_pkg::LimitW){1'b0}}, limit});
		beyond      = (diff > lim64) || (diff < -lim64);
		off_sum     = offset_q + diff[31:0];
		in_window   = ($signed(off_sum) < lim32) && ($signed(off_sum) > -lim32);
		do_resync   = (item.cmd == fce_pkg::CmdConvert) && item.read_ok && beyond;
		offset_next = offset_q;
		if (do_resync) begin
			offset_next = in_window ? 32'd0 : off_sum;
		end
	end

	// Result fields.
	always_comb begin
		result.local_count   = do_ext ? ext_local : 64'd0;
		result.kernel_target = (item.cmd == fce_pkg::CmdConvert) ?
			(item.target_count[31:0] - offset_next) : 32'd0;
	end

	// State update, once per committed transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			prev_q   <= '0;
			wrap_q   <= '0;
		end else if (commit) begin
			offset_q <= offset_next;
			if (do_ext) begin
				prev_q <= adj;
				wrap_q <= wrap_next;
			end
		end
	end

	// State holds between transactions.
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!commit |=> $stable(offset_q) && $stable(prev_q) && $stable(wrap_q))
		else $error("count state changed without a transaction");

	// The wrap count advances by at most one per transaction.
	a_wrap_step: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> (wrap_q == $past(wrap_q)) || (wrap_q == $past(wrap_q) + 32'd1))
		else $error("wrap count jumped by more than one");

	// A convert command with a failed read leaves the count state alone.
	a_failed_read_hold: assert property (@(posedge clk) disable iff (!arst_n)
		commit && (item.cmd == fce_pkg::CmdConvert) && !item.read_ok
		|=> $stable(offset_q) && $stable(prev_q) && $stable(wrap_q))
		else $error("failed read changed the count state");

endmodule

`default_nettype wire

FILE: sv/frame_counter_extender.sv
// Top level of the frame counter extender: input register, limit register,
// result register and handshake control around the datapath.
// Depends on fce_pkg and fce_datapath.
`default_nettype none

// Channel   Signals                               Direction  Payload
// item      item_valid, item_ready, item          in         fce_pkg::item_t
// result    result_valid, result_ready, result    out        fce_pkg::result_t
// config    cfg_wr_en, cfg_wr_data                in         30-bit offset limit
//
// One transaction per cycle sustained while result_ready stays high; an accepted
// item passes through the input register, then the result register, before its
// result is valid.
// The count state is updated as an item moves from the input register into the
// result register, so each item sees the state left by the one before it.
// A stalled result holds the input register; an empty result register frees it.
// Reset clears all valid flags and the count state and sets the limit to 1000.

module frame_counter_extender (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       item_valid,
	output logic                            item_ready,
	input  wire fce_pkg::item_t             item,
	output logic                            result_valid,
	input  wire logic                       result_ready,
	output fce_pkg::result_t                result,
	input  wire logic                       cfg_wr_en,
	input  wire logic [fce_pkg::LimitW-1:0] cfg_wr_data
);

	logic                       valid_s1;
	fce_pkg::item_t             item_s1;
	logic [fce_pkg::LimitW-1:0] limit_q;
	logic                       result_valid_q;
	fce_pkg::result_t           result_q;
	fce_pkg::result_t           result_next;
	logic                       advance;

	// Handshake: the stage moves on when the result register is free or draining.
	always_comb begin
		advance    = valid_s1 && (!result_valid_q || result_ready);
		item_ready = !valid_s1 || advance;
	end

	// Limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= fce_pkg::LimitReset;
		end else if (cfg_wr_en) begin
			limit_q <= cfg_wr_data;
		end
	end

	// Valid flags of the input and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (item_ready) begin
				valid_s1 <= item_valid;
			end
			if (advance) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
		if (advance) begin
			result_q <= result_next;
		end
	end

	fce_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.commit (advance),
		.item   (item_s1),
		.limit  (limit_q),
		.result (result_next)
	);

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// With the result register empty the block always takes a transaction.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid_q |-> item_ready)
		else $error("input stalled while the result register is empty");

	// An extend command gives a zero hardware target.
	a_extend_zero_target: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (item_s1.cmd == fce_pkg::CmdExtend) |=> result_q.kernel_target == 32'd0)
		else $error("extend command produced a nonzero hardware target");

	// A result transaction is never lost: a waiting result stays valid.
	a_result_kept: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && !result_ready |=> result_valid_q)
		else $error("pending result dropped");

endmodule

`default_nettype wire

FILE: verif/frame_count_checker.sv
// Checker for the frame counter extender: watches the item, result and limit channels.
// Predicts every result from its own copy of the count state and compares it field by field.
// Depends on fce_pkg.
`default_nettype none

module frame_count_checker
	import fce_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	input  wire logic              item_ready,
	input  wire item_t             item,
	input  wire logic              result_valid,
	input  wire logic              result_ready,
	input  wire result_t           result,
	input  wire logic              cfg_wr_en,
	input  wire logic [LimitW-1:0] cfg_wr_data,
	output int                     fail_count,
	output int                     pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// Shadow copy of the limit register and the count state.
	logic [LimitW-1:0] limit_q;
	logic [31:0]       offset_q;
	logic [31:0]       prev_q;
	logic [31:0]       wraps_q;

	// Results still owed by the block, oldest first.
	result_t expected_results[$];

	// Prints one line per mismatch, up to a cap, and counts every one.
	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (fail_count < 100) begin
			$display("%0t: %s: got %h, expected %h", $realtime, what, got, want);
		end
		fail_count++;
	endtask

	// Adds the offset to a raw count, tracks wraps and returns the 64-bit local count.
	function automatic logic [63:0] extend_count(input logic [31:0] raw);
		logic [31:0] adj;
		logic [31:0] delta;
		adj = raw + offset_q;
		delta = adj - prev_q;
		// A signed drop of more than the wrap window counts as one wrap.
		if (delta >= 32'h8000_0000 && delta < 32'd0 - WrapWindow) begin
			wraps_q = wraps_q + 32'd1;
		end
		prev_q = adj;
		return {wraps_q, adj};
	endfunction

	// Computes the result of one transaction and advances the shadow state.
	function automatic result_t predict_frame(input item_t it);
		result_t     res;
		logic [63:0] diff;
		logic [63:0] diff_mag;
		logic [31:0] off_mag;
		res = '0;
		if (it.cmd == CmdExtend) begin
			res.local_count = extend_count(it.kernel_count);
		end else begin
			if (it.read_ok) begin
				res.local_count = extend_count(it.kernel_count);
				diff = it.target_count - res.local_count;
				diff_mag = diff[63] ? 64'd0 - diff : diff;
				// Resynchronize the offset when the gap exceeds the limit.
				if (diff_mag > 64'(limit_q)) begin
					offset_q = offset_q + diff[31:0];
					off_mag = offset_q[31] ? 32'd0 - offset_q : offset_q;
					if (off_mag < 32'(limit_q)) begin
						offset_q = '0;
					end
				end
			end
			res.kernel_target = it.target_count[31:0] - offset_q;
		end
		return res;
	endfunction

	// Sample all channels at the clock edge: check results, then follow writes and items.
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			limit_q = LimitReset;
			offset_q = '0;
			prev_q = '0;
			wraps_q = '0;
			expected_results.delete();
		end else begin
			if (result_valid && result_ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result with no transaction pending",
						result.local_count, 64'd0);
				end else begin
					want = expected_results.pop_front();
					if (result.local_count !== want.local_count) begin
						report_mismatch("local_count", result.local_count,
							want.local_count);
					end
					if (result.kernel_target !== want.kernel_target) begin
						report_mismatch("kernel_target", 64'(result.kernel_target),
							64'(want.kernel_target));
					end
				end
			end
			if (cfg_wr_en) begin
				limit_q = cfg_wr_data;
			end
			if (item_valid && item_ready) begin
				expected_results.push_back(predict_frame(item));
			end
		end
		pending = expected_results.size();
	end

endmodule

`default_nettype wire

FILE: verif/tb_frame_counter_extender.sv
// Testbench top for the frame counter extender: clock, reset, stimulus and verdict.
// Depends on fce_pkg, frame_counter_extender and frame_count_checker.
`default_nettype none

module tb_frame_counter_extender;
	timeunit 1ns;
	timeprecision 1ps;
	import fce_pkg::*;

	localparam int CycleLimit = 1_500_000;
	localparam int PhaseItems = 200;
	localparam int NoiseStart = 180;
	localparam int PhaseCount = 8;
	localparam logic [LimitW-1:0] MaxLimit = '1;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              item_valid = 1'b0;
	logic              item_ready;
	item_t             item = '0;
	logic              result_valid;
	logic              result_ready = 1'b0;
	result_t           result;
	logic              cfg_wr_en = 1'b0;
	logic [LimitW-1:0] cfg_wr_data = '0;
	int                fail_count;
	int                pending;

	// Shared between the stimulus and the result sink.
	bit                quiet = 1'b0;
	bit                hold_req = 1'b0;
	logic [63:0]       last_local = '0;

	// Running hardware counter and the local count it is expected to map to.
	logic [31:0]       hw_count = '0;
	logic [63:0]       est_count = '0;
	logic [LimitW-1:0] cur_limit = LimitReset;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	frame_counter_extender u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data)
	);

	frame_count_checker u_checker (.*);

	// Mostly short gaps, some medium, a few long; none in quiet stretches.
	function automatic int rand_gap();
		int pick;
		pick = $urandom_range(0, 99);
		if (quiet || pick < 55) return 0;
		if (pick < 88) return $urandom_range(1, 3);
		if (pick < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic item_t make_item(input logic cmd, input logic [31:0] kc,
			input logic [63:0] tc, input logic ok);
		item_t it;
		it.cmd = cmd;
		it.kernel_count = kc;
		it.target_count = tc;
		it.read_ok = ok;
		return it;
	endfunction

	// Advances the hardware counter and builds either a plausible transaction or noise.
	function automatic item_t next_frame_item(input bit noise);
		item_t       it;
		logic [31:0] step;
		longint      dev;
		int          pick;
		pick = $urandom_range(0, 99);
		if (pick < 70) step = $urandom_range(1, 1000);
		else if (pick < 92) step = $urandom_range(1, 32'h1000_0000);
		else step = $urandom_range(32'h1000_0000, 32'h7FFF_FFFF);
		hw_count = hw_count + step;
		est_count = est_count + 64'(step);
		it.target_count = {$urandom, $urandom};
		it.read_ok = 1'($urandom);
		if (noise) begin
			it.cmd = 1'($urandom);
			it.kernel_count = $urandom;
			return it;
		end
		it.kernel_count = hw_count;
		if ($urandom_range(0, 99) < 45) begin
			it.cmd = CmdExtend;
		end else begin
			it.cmd = CmdConvert;
			it.read_ok = ($urandom_range(0, 9) != 0);
			// Targets mostly sit around the limit, sometimes far away.
			if ($urandom_range(0, 9) < 8) begin
				dev = longint'($urandom_range(0, 2 * cur_limit)) - longint'(cur_limit);
			end else begin
				dev = $signed({$urandom, $urandom}) >>> $urandom_range(16, 40);
			end
			it.target_count = est_count + 64'(dev);
			if (!it.read_ok) it.kernel_count = $urandom;
		end
		return it;
	endfunction

	// Offers one transaction, holds it until accepted, then idles for the gap.
	task automatic send_item(input item_t it, input int gap);
		item <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stops offering and waits until every expected result has come, plus the latency.
	task automatic drain();
		item_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_limit(input logic [LimitW-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		cur_limit = value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Cycle limit for the whole run.
	initial begin : watchdog
		repeat (CycleLimit) @(posedge clk);
		$display("frame_counter_extender: mismatch");
		$finish;
	end

	// Result side: random back-pressure, long hold-offs on request, records the last count.
	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (result_valid && result_ready) last_local = result.local_count;
			if (hold_req) begin
				hold_req = 1'b0;
				stall_left = 400;
			end
			if (stall_left > 0) begin
				result_ready <= 1'b0;
				stall_left--;
			end else if (quiet || $urandom_range(0, 99) < 65) begin
				result_ready <= 1'b1;
			end else begin
				result_ready <= 1'b0;
				stall_left = rand_gap();
			end
		end
	end

	// Stimulus: reset, directed transactions, then phases of random traffic per limit.
	initial begin : stimulus
		item_t             it;
		logic [LimitW-1:0] value;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part with the reset limit of 1000.
		// A difference of minus two to the 63rd counts as beyond the limit.
		send_item(make_item(CmdConvert, 32'h0, 64'h8000_0000_0000_0000, 1'b1), rand_gap());
		// Exactly at the limit, then one past it, then back to zero.
		send_item(make_item(CmdConvert, 32'h0, 64'd1000, 1'b1), rand_gap());
		send_item(make_item(CmdConvert, 32'h0, 64'd1001, 1'b1), rand_gap());
		send_item(make_item(CmdConvert, 32'h0, 64'd0, 1'b1), rand_gap());
		// A large offset, then one that lands inside the window and is cleared.
		send_item(make_item(CmdConvert, 32'h0, 64'd5000, 1'b1), rand_gap());
		send_item(make_item(CmdConvert, 32'h0, 64'd500, 1'b1), rand_gap());
		// Failed reads leave the state alone.
		send_item(make_item(CmdConvert, 32'hFFFF_FFFF, '1, 1'b0), rand_gap());
		send_item(make_item(CmdConvert, 32'h0, 64'd0, 1'b0), rand_gap());
		// Extend ignores the target and read flag; walk the wrap window edges.
		send_item(make_item(CmdExtend, 32'hFFFF_FFFF, '1, 1'b1), rand_gap());
		send_item(make_item(CmdExtend, 32'h8000_0000, 64'd0, 1'b0), rand_gap());
		send_item(make_item(CmdExtend, 32'h0, '1, 1'b0), rand_gap());
		send_item(make_item(CmdExtend, 32'hC000_0000, 64'd0, 1'b1), rand_gap());
		send_item(make_item(CmdExtend, 32'h7FFF_FFFF, 64'd0, 1'b0), rand_gap());
		send_item(make_item(CmdConvert, 32'hFFFF_FFFF, '1, 1'b1), rand_gap());
		send_item(make_item(CmdConvert, 32'h0, 64'd0, 1'b1), rand_gap());
		send_item(make_item(CmdExtend, 32'h5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0), 0);
		send_item(make_item(CmdExtend, 32'hAAAA_AAAA, 64'h5555_5555_5555_5555, 1'b1), 0);

		hw_count = $urandom_range(0, 32'h0FFF_FFFF);
		for (int p = 0; p < PhaseCount; p++) begin
			drain();
			case (p)
				0: value = LimitW'(1);
				1: value = MaxLimit;
				2: value = LimitReset;
				3: value = LimitW'(16);
				4: value = LimitW'($urandom_range(1, MaxLimit));
				5: value = MaxLimit - LimitW'(1);
				6: value = LimitW'($urandom_range(1, 4096));
				default: value = LimitW'(2);
			endcase
			write_limit(value);
			quiet = (p == 2);

			// Line the expected local count up with the block before the phase.
			it = make_item(CmdExtend, hw_count, 64'd0, 1'b0);
			send_item(it, 0);
			drain();
			est_count = last_local;

			for (int i = 0; i < PhaseItems; i++) begin
				// Block the result side for a long time while items keep coming.
				if (p == 1 && i == 50) begin
					hold_req = 1'b1;
					repeat (30) send_item(next_frame_item(1'b0), 0);
				end
				send_item(next_frame_item(i >= NoiseStart), rand_gap());
			end
			quiet = 1'b0;
		end

		drain();
		if (fail_count == 0 && pending == 0) begin
			$display("frame_counter_extender: match");
		end else begin
			$display("frame_counter_extender: mismatch");
		end
		$finish;
	end

endmodule

`default_nettype wire
